// ----- src/crs_pkg.sv -----
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the clip rectangle stack
// Stack size, opcode and status codes, register indexes and the region
// record held by each stack cell.
// ----------------------------------------------------------------------------
package crs_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int CFG_IDX_W   = 4;

    typedef enum logic [2:0] {
        OP_CLIP       = 3'd0,
        OP_HIT_TEST   = 3'd1,
        OP_PUSH       = 3'd2,
        OP_PUSH_EMPTY = 3'd3,
        OP_POP        = 3'd4,
        OP_REPLACE    = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 4'd3;

    // One stacked clip region
    typedef struct packed {
        logic               empty;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic        [15:0] w;
        logic        [15:0] h;
    } region_t;

    // Shift control for one cell
    typedef struct packed {
        logic take_up;   // load from the cell above (or new data at the head)
        logic take_dn;   // load from the cell below
    } cell_cmd_t;

endpackage

// ----- src/crs_cell.sv -----
// ----------------------------------------------------------------------------
// crs_cell: one stack cell
// Holds one clip region; shifts down on push, up on pop, else holds.
// ----------------------------------------------------------------------------
module crs_cell
    import crs_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  region_t   up_region,
    input  region_t   dn_region,
    output region_t   region
);

    region_t region_reg;
    region_t region_next;

    always_comb
    begin
        priority if (cmd.take_up)
        begin
            region_next = up_region;
        end
        else if (cmd.take_dn)
        begin
            region_next = dn_region;
        end
        else
        begin
            region_next = region_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        region_reg <= region_next;
    end

    assign region = region_reg;

endmodule

// ----- src/crs_axis.sv -----
// ----------------------------------------------------------------------------
// crs_axis: clamp one axis of a rectangle to a region
// Length is max(0, min(last, reg_last) - max(pos, reg_pos) + 1).
// ----------------------------------------------------------------------------
module crs_axis
    import crs_pkg::*;
(
    input  logic signed [16:0] pos,
    input  logic        [15:0] len,
    input  logic signed [18:0] last,       // pos + len - 1
    input  logic signed [16:0] reg_pos,
    input  logic signed [18:0] reg_last,   // region start + length - 1
    output logic signed [16:0] clip_pos,
    output logic        [15:0] clip_len,
    output logic               moved
);

    logic signed [18:0] pos_w;
    logic signed [18:0] rpos_w;
    logic signed [18:0] lo;
    logic signed [18:0] hi;
    logic signed [19:0] span;
    logic               below;
    logic               beyond;

    always_comb
    begin
        pos_w    = 19'(pos);
        rpos_w   = 19'(reg_pos);
        below    = pos_w < rpos_w;
        beyond   = pos_w > reg_last;
        lo       = below ? rpos_w : pos_w;
        hi       = (last < reg_last) ? last : reg_last;
        span     = 20'(hi) - 20'(lo) + 20'sd1;
        clip_len = (span <= 20'sd0) ? 16'd0 : span[15:0];
        // past the far edge the position sits on the last column
        clip_pos = below ? reg_pos : (beyond ? reg_last[16:0] : pos);
        moved    = below | beyond | (clip_len != len);
    end

endmodule

// ----- src/clip_rectangle_stack.sv -----
// ----------------------------------------------------------------------------
// clip_rectangle_stack: 2D clip unit with a stack of clip regions
// Clips offset rectangles to the top region or the screen, runs intersect
// tests and pushes, pops and replaces regions held in a shifting row of cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one request: opcode plus a
//    rectangle. Output channel (out_valid/out_ready) returns exactly one
//    result per request, in order.
//  - Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is
//    always ready; write it only while no request is in flight.
//  - Flow: a request is registered in the input stage and its result in
//    the output register. The input stage takes no new request until the
//    last one has left it. The head cell's region bounds are registered
//    behind every stack update, and the next request reads them, so only
//    one request is worked at a time.
//  - Stall: while the output register holds an untaken result, one more
//    request may be accepted and waits in the input stage; in_ready then
//    drops until the result is taken.
//  - Reset: stack empty, offsets 0, screen 80 x 25. Stack cells are not
//    cleared; an entry is only read after it has been written.
// ----------------------------------------------------------------------------
module clip_rectangle_stack
    import crs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic signed [15:0]   rect_x,
    input  logic signed [15:0]   rect_y,
    input  logic [15:0]          rect_w,
    input  logic [15:0]          rect_h,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [16:0]   clip_x,
    output logic signed [16:0]   clip_y,
    output logic [15:0]          clip_w,
    output logic [15:0]          clip_h,
    output logic                 changed,
    output logic                 hits,
    output logic [1:0]           status,
    output logic [4:0]           depth_after
);

    // ---------------- configuration registers ----------------
    logic signed [15:0] offset_x_reg;
    logic signed [15:0] offset_y_reg;
    logic        [15:0] screen_cols_reg;
    logic        [15:0] screen_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            screen_cols_reg <= 16'd80;
            screen_rows_reg <= 16'd25;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_OFFSET_X)    offset_x_reg    <= cfg_data;
            if (cfg_index == CFG_OFFSET_Y)    offset_y_reg    <= cfg_data;
            if (cfg_index == CFG_SCREEN_COLS) screen_cols_reg <= cfg_data;
            if (cfg_index == CFG_SCREEN_ROWS) screen_rows_reg <= cfg_data;
        end
    end

    // screen region last column/row, registered from config
    logic signed [18:0] scr_lastx_reg;
    logic signed [18:0] scr_lasty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_lastx_reg <= 19'sd79;
            scr_lasty_reg <= 19'sd24;
        end
        else
        begin
            scr_lastx_reg <= $signed({3'b000, screen_cols_reg}) - 19'sd1;
            scr_lasty_reg <= $signed({3'b000, screen_rows_reg}) - 19'sd1;
        end
    end

    // ---------------- input stage: apply offset, precompute ends ----------------
    logic               s1_valid_reg;
    logic [2:0]         s1_op_reg;
    logic signed [16:0] s1_px_reg;
    logic signed [16:0] s1_py_reg;
    logic [15:0]        s1_w_reg;
    logic [15:0]        s1_h_reg;
    logic signed [18:0] s1_endx_reg;     // px + w, one past the right edge
    logic signed [18:0] s1_endy_reg;
    logic signed [18:0] s1_lastx_reg;    // px + w - 1
    logic signed [18:0] s1_lasty_reg;

    logic               in_fire;
    logic               s2_fire;
    logic signed [16:0] px_c;
    logic signed [16:0] py_c;
    logic signed [18:0] endx_c;
    logic signed [18:0] endy_c;

    assign in_ready = !s1_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        px_c   = 17'(rect_x) + 17'(offset_x_reg);
        py_c   = 17'(rect_y) + 17'(offset_y_reg);
        endx_c = 19'(px_c) + $signed({3'b000, rect_w});
        endy_c = 19'(py_c) + $signed({3'b000, rect_h});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= opcode;
            s1_px_reg    <= px_c;
            s1_py_reg    <= py_c;
            s1_w_reg     <= rect_w;
            s1_h_reg     <= rect_h;
            s1_endx_reg  <= endx_c;
            s1_endy_reg  <= endy_c;
            s1_lastx_reg <= endx_c - 19'sd1;
            s1_lasty_reg <= endy_c - 19'sd1;
        end
    end

    // ---------------- stack: row of cells, cell 0 is the top ----------------
    region_t   cell_q   [STACK_DEPTH];
    cell_cmd_t cell_cmd [STACK_DEPTH];
    region_t   new_region;
    logic      do_push;
    logic      do_pop;
    logic      do_replace;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        region_t up_r;
        region_t dn_r;

        if (i == 0)
        begin : g_head
            assign up_r = new_region;
            assign cell_cmd[i].take_up = do_push || do_replace;
        end
        else
        begin : g_body
            assign up_r = cell_q[i-1];
            assign cell_cmd[i].take_up = do_push;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign dn_r = cell_q[i];
        end
        else
        begin : g_mid
            assign dn_r = cell_q[i+1];
        end

        assign cell_cmd[i].take_dn = do_pop;

        crs_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd[i]),
            .up_region (up_r),
            .dn_region (dn_r),
            .region    (cell_q[i])
        );
    end

    // head region bounds, registered from the head cell after any stack update
    logic signed [18:0] top_lastx_reg;
    logic signed [18:0] top_lasty_reg;
    logic signed [18:0] top_endx_reg;
    logic signed [18:0] top_endy_reg;

    always_ff @(posedge clk)
    begin
        top_endx_reg  <= 19'(cell_q[0].x) + $signed({3'b000, cell_q[0].w});
        top_endy_reg  <= 19'(cell_q[0].y) + $signed({3'b000, cell_q[0].h});
        top_lastx_reg <= 19'(cell_q[0].x) + $signed({3'b000, cell_q[0].w}) - 19'sd1;
        top_lasty_reg <= 19'(cell_q[0].y) + $signed({3'b000, cell_q[0].h}) - 19'sd1;
    end

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               stack_full;
    logic               stack_none;
    logic               region_real;

    assign stack_full  = depth_reg == DEPTH_W'(STACK_DEPTH);
    assign stack_none  = depth_reg == '0;
    assign region_real = !stack_none && !cell_q[0].empty;

    // ---------------- clipping against the active region ----------------
    logic signed [16:0] reg_x;
    logic signed [16:0] reg_y;
    logic signed [18:0] reg_lastx;
    logic signed [18:0] reg_lasty;
    logic signed [16:0] ax_x;
    logic signed [16:0] ax_y;
    logic [15:0]        ax_w;
    logic [15:0]        ax_h;
    logic               ax_moved_x;
    logic               ax_moved_y;

    assign reg_x     = region_real ? cell_q[0].x   : 17'sd0;
    assign reg_y     = region_real ? cell_q[0].y   : 17'sd0;
    assign reg_lastx = region_real ? top_lastx_reg : scr_lastx_reg;
    assign reg_lasty = region_real ? top_lasty_reg : scr_lasty_reg;

    crs_axis u_axis_x (
        .pos      (s1_px_reg),
        .len      (s1_w_reg),
        .last     (s1_lastx_reg),
        .reg_pos  (reg_x),
        .reg_last (reg_lastx),
        .clip_pos (ax_x),
        .clip_len (ax_w),
        .moved    (ax_moved_x)
    );

    crs_axis u_axis_y (
        .pos      (s1_py_reg),
        .len      (s1_h_reg),
        .last     (s1_lasty_reg),
        .reg_pos  (reg_y),
        .reg_last (reg_lasty),
        .clip_pos (ax_y),
        .clip_len (ax_h),
        .moved    (ax_moved_y)
    );

    // zero-length rectangles pass through untouched
    logic               clip_active;
    logic signed [16:0] cr_x;
    logic signed [16:0] cr_y;
    logic [15:0]        cr_w;
    logic [15:0]        cr_h;
    logic               cr_changed;
    logic               touch;

    always_comb
    begin
        clip_active = (s1_w_reg != '0) && (s1_h_reg != '0);
        cr_x        = clip_active ? ax_x : s1_px_reg;
        cr_y        = clip_active ? ax_y : s1_py_reg;
        cr_w        = clip_active ? ax_w : s1_w_reg;
        cr_h        = clip_active ? ax_h : s1_h_reg;
        cr_changed  = clip_active && (ax_moved_x || ax_moved_y);
        // edges count as touching; no real region means always a hit
        touch = !region_real
             || !((s1_endx_reg < 19'(cell_q[0].x)) || (19'(s1_px_reg) > top_endx_reg)
               || (s1_endy_reg < 19'(cell_q[0].y)) || (19'(s1_py_reg) > top_endy_reg));
    end

    // ---------------- opcode decode and stack update ----------------
    logic               out_valid_reg;
    logic signed [16:0] clip_x_reg,  clip_x_next;
    logic signed [16:0] clip_y_reg,  clip_y_next;
    logic [15:0]        clip_w_reg,  clip_w_next;
    logic [15:0]        clip_h_reg,  clip_h_next;
    logic               changed_reg, changed_next;
    logic               hits_reg,    hits_next;
    status_t            status_reg,  status_next;
    logic               show;

    assign s2_fire = s1_valid_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        do_push     = 1'b0;
        do_pop      = 1'b0;
        do_replace  = 1'b0;
        show        = 1'b0;
        hits_next   = 1'b0;
        status_next = ST_DONE;
        depth_next  = depth_reg;
        new_region  = '{empty: 1'b0, x: cr_x, y: cr_y, w: cr_w, h: cr_h};

        unique case (opcode_t'(s1_op_reg))
            OP_CLIP:
            begin
                show = 1'b1;
            end
            OP_HIT_TEST:
            begin
                hits_next = touch;
            end
            OP_PUSH:
            begin
                if (stack_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push    = s2_fire;
                    show       = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            OP_PUSH_EMPTY:
            begin
                new_region = '{empty: 1'b1, x: '0, y: '0, w: '0, h: '0};
                if (stack_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push    = s2_fire;
                    depth_next = depth_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                if (stack_none)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    do_pop     = s2_fire;
                    depth_next = depth_reg - 1'b1;
                end
            end
            OP_REPLACE:
            begin
                // replace on an empty stack is a push
                show = 1'b1;
                if (stack_none)
                begin
                    do_push    = s2_fire;
                    depth_next = depth_reg + 1'b1;
                end
                else
                begin
                    do_replace = s2_fire;
                end
            end
            default:
            begin
                show = 1'b0;
            end
        endcase

        clip_x_next  = show ? cr_x       : 17'sd0;
        clip_y_next  = show ? cr_y       : 17'sd0;
        clip_w_next  = show ? cr_w       : 16'd0;
        clip_h_next  = show ? cr_h       : 16'd0;
        changed_next = show ? cr_changed : 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_fire)
            begin
                depth_reg <= depth_next;
            end
            out_valid_reg <= s2_fire || (out_valid_reg && !out_ready);
        end
    end

    logic [DEPTH_W-1:0] out_depth_reg;

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            clip_x_reg    <= clip_x_next;
            clip_y_reg    <= clip_y_next;
            clip_w_reg    <= clip_w_next;
            clip_h_reg    <= clip_h_next;
            changed_reg   <= changed_next;
            hits_reg      <= hits_next;
            status_reg    <= status_next;
            out_depth_reg <= depth_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign clip_x      = clip_x_reg;
    assign clip_y      = clip_y_reg;
    assign clip_w      = clip_w_reg;
    assign clip_h      = clip_h_reg;
    assign changed     = changed_reg;
    assign hits        = hits_reg;
    assign status      = status_reg;
    assign depth_after = 5'(out_depth_reg);

    // ---------------- assertions ----------------
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth past its bound");

    a_full_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_FULL) |-> out_depth_reg == DEPTH_W'(STACK_DEPTH))
        else $error("push refused on a stack that was not full");

    a_empty_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == ST_EMPTY) |-> out_depth_reg == '0)
        else $error("pop refused on a stack that was not empty");

    a_hit_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && hits_reg |-> (clip_w_reg == '0) && !changed_reg
                                      && (status_reg == ST_DONE))
        else $error("intersect result mixed with clip fields");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s2_fire && !in_fire |=> !s1_valid_reg)
        else $error("input stage not released after completion");

endmodule
